// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the keyed byte transform cipher.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while the synchronous active-low reset is held.
`define KBTC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define KBTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/kbtc_pkg.sv =====
// Package for the keyed byte transform cipher: sizes, codes and shared types.
// No dependencies; imported by every RTL module of the block except kbtc_key_ram.
`default_nettype none

package kbtc_pkg;

    // Key table geometry
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_W     = 11;

    // Field widths
    localparam int LEN_W  = 9;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 32;

    // Longest usable key length: the table depth, or all that the register can hold
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((KEY_DEPTH > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : KEY_DEPTH);

    // Item operations, carried in tuser
    typedef enum logic [1:0] {
        OP_WRITE_KEY = 2'd0,
        OP_SET_POS   = 2'd1,
        OP_ENCRYPT   = 2'd2,
        OP_DECRYPT   = 2'd3
    } kbtc_op_t;

    // Transform modes of a key entry
    typedef enum logic [2:0] {
        MODE_PASS    = 3'd0,
        MODE_XOR     = 3'd1,
        MODE_XNOR    = 3'd2,
        MODE_MIRROR  = 3'd3,
        MODE_MIR_XOR = 3'd4,
        MODE_ROT_A   = 3'd5,
        MODE_ROT_B   = 3'd6,
        MODE_INVERT  = 3'd7
    } kbtc_mode_t;

    // One key table entry
    typedef struct packed {
        kbtc_mode_t        mode;
        logic [BYTE_W-1:0] kbyte;
    } key_entry_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_XFORM,
        S_SETPOS
    } kbtc_state_t;

    // Position modulo unit: request and response
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LEN_W-1:0] remainder;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/kbtc_key_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
// Holds the key table; no package dependencies.
`default_nettype none

module kbtc_key_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 11,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kbtc_pos_mod.sv =====
// Iterative remainder unit for the set-position operation: one dividend bit per cycle.
// Depends on kbtc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kbtc_pos_mod
    import kbtc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mod_req_t req,
    output mod_rsp_t      rsp
);

    localparam int CNT_W = $clog2(BYTE_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [BYTE_W-1:0]   div_reg, div_next;
    logic [LEN_W-1:0]    divisor_reg, divisor_next;
    logic [LEN_W:0]      trial;

    // Restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial        = {rem_reg, div_reg[BYTE_W-1]};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(BYTE_W);
            rem_next     = '0;
            div_next     = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor_reg}) begin
                rem_next = LEN_W'(trial - {1'b0, divisor_reg});
            end else begin
                rem_next = trial[LEN_W-1:0];
            end
            div_next = {div_reg[BYTE_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    `KBTC_ASSERT(a_rem_below_divisor, aclk, aresetn,
        done_reg |-> (divisor_reg == '0 || rem_reg < divisor_reg),
        "remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/kbtc_xform.sv =====
// Byte transform selected by a key entry's mode, for either direction.
// Depends on kbtc_pkg.
`default_nettype none

module kbtc_xform
    import kbtc_pkg::*;
(
    input  wire logic [BYTE_W-1:0] x,
    input  wire key_entry_t        entry,
    input  wire logic              enc,
    output logic      [BYTE_W-1:0] y
);

    logic [BYTE_W-1:0]   k;
    logic [BYTE_W-1:0]   x_mir;
    logic [BYTE_W-1:0]   xk_mir;
    logic [BYTE_W-1:0]   xk;
    logic [2*BYTE_W-1:0] dbl;
    logic [2*BYTE_W-1:0] dbl_l;
    logic [2*BYTE_W-1:0] dbl_r;
    logic [BYTE_W-1:0]   rot_l;
    logic [BYTE_W-1:0]   rot_r;
    logic [2:0]          sh;

    assign k  = entry.kbyte;
    assign xk = x ^ k;
    assign sh = k[2:0];

    // Bit mirrors
    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            x_mir[i]  = x[BYTE_W-1-i];
            xk_mir[i] = xk[BYTE_W-1-i];
        end
    end

    // Rotations by key mod 8 through a doubled word
    assign dbl   = {x, x};
    assign dbl_l = dbl << sh;
    assign dbl_r = dbl >> sh;
    assign rot_l = dbl_l[2*BYTE_W-1:BYTE_W];
    assign rot_r = dbl_r[BYTE_W-1:0];

    // Mode select; mirror-xor and the rotations differ by direction
    always_comb begin
        case (entry.mode)
            MODE_PASS:    y = x;
            MODE_XOR:     y = xk;
            MODE_XNOR:    y = ~xk;
            MODE_MIRROR:  y = x_mir;
            MODE_MIR_XOR: y = enc ? (x_mir ^ k) : xk_mir;
            MODE_ROT_A:   y = enc ? rot_l : rot_r;
            MODE_ROT_B:   y = enc ? rot_r : rot_l;
            MODE_INVERT:  y = ~x;
            default:      y = x;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/keyed_byte_transform_cipher.sv =====
// Keyed byte transform cipher: cyclic key table, position and plaintext checksum.
// Depends on kbtc_pkg, kbtc_key_ram, kbtc_pos_mod, kbtc_xform and assert_macros.svh.
//
// Each transfer on the s_ side carries an operation in tuser: write a key entry, set the
// key position, encrypt a byte or decrypt a byte. Encrypt and decrypt give one transfer
// on the m_ side with the result byte, the 32-bit plaintext checksum after that byte and
// the position the next byte will use; the other operations give none. For an encrypt
// or decrypt the key entry is read from the table RAM in the accept cycle; the byte is
// then transformed and registered in the transform state, which waits while the output
// register is full and not taken. A set position with key_length zero clears the position
// in the accept cycle; otherwise the bit-serial remainder unit works through the eight
// address bits. The output register lets the next item be accepted while a result still
// waits. key_length must be written through cfg_wr_en only while idle; the block does not
// enforce it; key entries must be written before they are used.
`default_nettype none
`include "assert_macros.svh"

module keyed_byte_transform_cipher
    import kbtc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [LEN_W-1:0]  cfg_wr_data,   // key_length
    // Input items
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [7:0] data_byte, [15:8] key_address, [23:16] key_cipher_byte, [26:24] key_mode
    input  wire logic [31:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,       // [1:0] operation
    // Result items
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [7:0] result_byte, [39:8] running_sum, [47:40] next_position
    output logic      [47:0]       m_tdata
);

    // Input fields
    kbtc_op_t          op;
    logic [BYTE_W-1:0] in_data;
    logic [BYTE_W-1:0] in_addr;
    key_entry_t        in_entry;

    assign op             = kbtc_op_t'(s_tuser);
    assign in_data        = s_tdata[7:0];
    assign in_addr        = s_tdata[15:8];
    assign in_entry.kbyte = s_tdata[23:16];
    assign in_entry.mode  = kbtc_mode_t'(s_tdata[26:24]);

    // State
    kbtc_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  key_length_reg, key_length_next;
    logic [KEY_AW-1:0] key_position_reg, key_position_next;
    logic [SUM_W-1:0]  checksum_reg, checksum_next;

    // Item held during the transform cycle
    logic              enc_reg, enc_next;
    logic              bypass_reg, bypass_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [KEY_AW-1:0] pos_reg, pos_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] res_reg, res_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] npos_reg, npos_next;

    // Key table and helpers
    logic              ram_we;
    logic              ram_re;
    logic [KEY_AW-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_rdata;
    key_entry_t        rd_entry;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;
    logic [BYTE_W-1:0] xf_y;

    logic              s_accept;
    logic              out_free;
    logic [LEN_W-1:0]  len_act;
    logic [KEY_AW-1:0] pos_eff;
    logic [31:0]       pos_plus;
    logic [KEY_AW-1:0] pos_inc;
    logic              addr_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Length in use, position clamped to the table, next position with wrap
    assign len_act   = (key_length_reg > LEN_CAP) ? LEN_CAP : key_length_reg;
    assign pos_eff   = (32'(key_position_reg) < 32'(len_act)) ? key_position_reg : '0;
    assign pos_plus  = 32'(pos_reg) + 32'd1;
    assign pos_inc   = (pos_plus >= 32'(len_act)) ? '0 : KEY_AW'(pos_plus);
    assign addr_ok   = 32'(in_addr) < 32'(KEY_DEPTH);
    assign ram_waddr = KEY_AW'(in_addr);
    assign rd_entry  = key_entry_t'(ram_rdata);

    kbtc_key_ram #(
        .DEPTH (KEY_DEPTH),
        .WIDTH (KEY_W)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (KEY_W'(in_entry)),
        .rd_en   (ram_re),
        .rd_addr (pos_eff),
        .rd_data (ram_rdata)
    );

    kbtc_pos_mod u_pos_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    kbtc_xform u_xform (
        .x     (data_reg),
        .entry (rd_entry),
        .enc   (enc_reg),
        .y     (xf_y)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (op) inside
                        OP_ENCRYPT, OP_DECRYPT: state_next = S_XFORM;
                        OP_SET_POS: state_next = (len_act == '0) ? S_IDLE : S_SETPOS;
                        OP_WRITE_KEY: state_next = S_IDLE;
                    endcase
                end
            end
            S_XFORM: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SETPOS: begin
                if (mod_rsp.done) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        key_length_next   = key_length_reg;
        key_position_next = key_position_reg;
        checksum_next     = checksum_reg;
        enc_next          = enc_reg;
        bypass_next       = bypass_reg;
        data_next         = data_reg;
        pos_next          = pos_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        res_next          = res_reg;
        sum_next          = sum_reg;
        npos_next         = npos_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        mod_req.start     = 1'b0;
        mod_req.dividend  = in_addr;
        mod_req.divisor   = len_act;

        if (cfg_wr_en) begin
            key_length_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (op) inside
                        OP_WRITE_KEY: ram_we = addr_ok;
                        OP_SET_POS: begin
                            if (len_act == '0) begin
                                key_position_next = '0;
                            end else begin
                                mod_req.start = 1'b1;
                            end
                        end
                        OP_ENCRYPT, OP_DECRYPT: begin
                            enc_next    = (op == OP_ENCRYPT);
                            bypass_next = (len_act == '0);
                            data_next   = in_data;
                            pos_next    = pos_eff;
                            ram_re      = 1'b1;
                        end
                    endcase
                end
            end
            S_XFORM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (bypass_reg) begin
                        res_next = data_reg;
                    end else begin
                        res_next          = xf_y;
                        checksum_next     = checksum_reg
                                          + SUM_W'(enc_reg ? data_reg : xf_y);
                        key_position_next = pos_inc;
                    end
                    sum_next  = checksum_next;
                    npos_next = BYTE_W'(key_position_next);
                end
            end
            S_SETPOS: begin
                if (mod_rsp.done) begin
                    key_position_next = KEY_AW'(mod_rsp.remainder);
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            key_length_reg   <= '0;
            key_position_reg <= '0;
            checksum_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            key_length_reg   <= key_length_next;
            key_position_reg <= key_position_next;
            checksum_reg     <= checksum_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        enc_reg    <= enc_next;
        bypass_reg <= bypass_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        res_reg    <= res_next;
        sum_reg    <= sum_next;
        npos_reg   <= npos_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {npos_reg, sum_reg, res_reg};

    `KBTC_ASSERT(a_crypt_goes_xform, aclk, aresetn,
        (s_accept && (op == OP_ENCRYPT || op == OP_DECRYPT)) |=> (state_reg == S_XFORM),
        "byte transfer did not enter the transform cycle")
    `KBTC_ASSERT(a_xform_loads_output, aclk, aresetn,
        (state_reg == S_XFORM && out_free) |=> (m_valid_reg && state_reg == S_IDLE),
        "transform cycle did not load the output register")
    `KBTC_ASSERT(a_result_from_xform, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(state_reg == S_XFORM),
        "result appeared without a transform cycle")

endmodule

`default_nettype wire
